// File: src/wrb_pkg.sv
package wrb_pkg;

   // Input item action codes
   typedef enum logic [3:0] {
      ACT_CTS        = 4'd0,
      ACT_BLOCKACK   = 4'd1,
      ACT_ACK        = 4'd2,
      ACT_DATA_FAIL  = 4'd3,
      ACT_RTS_FAIL   = 4'd4,
      ACT_GROUP_SENT = 4'd5,
      ACT_QUERY_DATA = 4'd6,
      ACT_QUERY_RTS  = 4'd7,
      ACT_CLEAR_SLOT = 4'd8
   } action_type;

   // Register indexes (byte address = 4 * index)
   localparam logic [2:0] REG_SHORT_LIMIT = 3'd0;
   localparam logic [2:0] REG_LONG_LIMIT  = 3'd1;
   localparam logic [2:0] REG_WINDOW_MIN  = 3'd2;
   localparam logic [2:0] REG_WINDOW_MAX  = 3'd3;
   localparam logic [2:0] REG_LEN_THRESH  = 3'd4;

   localparam logic [7:0]  SHORT_LIMIT_RST = 8'd7;
   localparam logic [7:0]  LONG_LIMIT_RST  = 8'd4;
   localparam logic [14:0] WINDOW_MIN_RST  = 15'd15;
   localparam logic [14:0] WINDOW_MAX_RST  = 15'd1023;
   localparam logic [15:0] LEN_THRESH_RST  = 16'd2346;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 48;

   localparam logic [7:0] COUNT_MAX = 8'd255;

   typedef struct packed {
      logic [7:0]  short_limit;
      logic [7:0]  long_limit;
      logic [14:0] window_min;
      logic [14:0] window_max;
      logic [15:0] length_threshold;
   } cfg_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load;   // capture the accepted request
      logic exec;   // apply the event and register the response
   } cmd_type;

   function automatic logic [7:0] sat_inc(input logic [7:0] value);
      sat_inc = (value == COUNT_MAX) ? COUNT_MAX : value + 8'd1;
   endfunction

endpackage

// File: src/wifi_retry_backoff_tracker.sv
// 802.11 retry counter and contention window tracker.
// Request stream (req_*): one transfer per event - CTS, BlockAck, ACK, data
// failure, RTS failure, group sent, data/RTS limit query, slot clear.
// Response stream (rsp_*): exactly one transfer per request, carrying the
// window and station counts after the event, the relevant slot count, a
// limit flag and a missing-entry flag for queries.
// Register port (csr_*): retry limits, window bounds and the long-frame
// length threshold at byte addresses 0, 4, 8, 12, 16; zero wait states.
// Timing: a request is taken in the idle cycle, applied in the next cycle,
// and its response is valid from the cycle after that. The state sequencer
// handles one item at a time: the next request is taken only after the
// response of the last one has been accepted by the receiver.
// Reset (synchronous, active high) restores register defaults, clears the
// station counts and all slot entries, and sets the window to its minimum.
// When the receiver stalls the response holds and no new request is taken.
module wifi_retry_backoff_tracker #(
   parameter int FRAME_SLOTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // Request: [3:0] action, [7:4] frame_slot, [23:8] frame_length
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,
   // Response: [14:0] window_now, [22:15] station_short_now,
   // [30:23] station_long_now, [38:31] frame_retries, [39] limit_reached,
   // [40] entry_missing, [47:41] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,
   // Register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   wrb_pkg::cfg_type cfg;
   wrb_pkg::cmd_type cmd;

   // Configuration registers
   wrb_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Sequencer: accept, apply, present
   wrb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   // Counters, window, slot table and response register
   wrb_dpath #(
      .FRAME_SLOTS (FRAME_SLOTS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd       (cmd),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata)
   );

endmodule

// File: src/wrb_csr.sv
module wrb_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [4:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready,
   output wrb_pkg::cfg_type cfg
);

   logic [7:0]  short_limit_ff;
   logic [7:0]  long_limit_ff;
   logic [14:0] window_min_ff;
   logic [14:0] window_max_ff;
   logic [15:0] len_thresh_ff;
   logic        wr_en;
   logic [2:0]  reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign reg_idx    = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         short_limit_ff <= wrb_pkg::SHORT_LIMIT_RST;
         long_limit_ff  <= wrb_pkg::LONG_LIMIT_RST;
         window_min_ff  <= wrb_pkg::WINDOW_MIN_RST;
         window_max_ff  <= wrb_pkg::WINDOW_MAX_RST;
         len_thresh_ff  <= wrb_pkg::LEN_THRESH_RST;
      end else if (wr_en) begin
         unique case (reg_idx)
            wrb_pkg::REG_SHORT_LIMIT: short_limit_ff <= csr_pwdata[7:0];
            wrb_pkg::REG_LONG_LIMIT:  long_limit_ff  <= csr_pwdata[7:0];
            wrb_pkg::REG_WINDOW_MIN:  window_min_ff  <= csr_pwdata[14:0];
            wrb_pkg::REG_WINDOW_MAX:  window_max_ff  <= csr_pwdata[14:0];
            wrb_pkg::REG_LEN_THRESH:  len_thresh_ff  <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         wrb_pkg::REG_SHORT_LIMIT: csr_prdata = {24'd0, short_limit_ff};
         wrb_pkg::REG_LONG_LIMIT:  csr_prdata = {24'd0, long_limit_ff};
         wrb_pkg::REG_WINDOW_MIN:  csr_prdata = {17'd0, window_min_ff};
         wrb_pkg::REG_WINDOW_MAX:  csr_prdata = {17'd0, window_max_ff};
         wrb_pkg::REG_LEN_THRESH:  csr_prdata = {16'd0, len_thresh_ff};
         default:                  csr_prdata = 32'd0;
      endcase
   end

   assign cfg.short_limit      = short_limit_ff;
   assign cfg.long_limit       = long_limit_ff;
   assign cfg.window_min       = window_min_ff;
   assign cfg.window_max       = window_max_ff;
   assign cfg.length_threshold = len_thresh_ff;

endmodule

// File: src/wrb_ctrl.sv
module wrb_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output wrb_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_EXEC = 3'b010,
      S_RESP = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_EXEC;
         end
         S_EXEC: state_in = S_RESP;
         S_RESP: begin
            if (rsp_tready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_RESP);
   assign cmd.load   = req_tready & req_tvalid;
   assign cmd.exec   = (state_ff == S_EXEC);

endmodule

// File: src/wrb_dpath.sv
module wrb_dpath #(
   parameter int FRAME_SLOTS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  wrb_pkg::cfg_type                 cfg,
   input  wrb_pkg::cmd_type                 cmd,
   input  logic [wrb_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic [wrb_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   // Only sixteen slots are addressable by a 4-bit slot field
   localparam int SLOT_DEPTH = (FRAME_SLOTS < 16) ? FRAME_SLOTS : 16;
   localparam int SLOT_AW    = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
   localparam logic [8:0] SLOT_LIMIT = 9'(FRAME_SLOTS);

   // Captured request
   logic [3:0]  action_ff;
   logic [3:0]  slot_ff;
   logic [15:0] length_ff;

   // Retry state
   logic [14:0] window_ff,      window_in;
   logic [7:0]  sta_short_ff,   sta_short_in;
   logic [7:0]  sta_long_ff,    sta_long_in;
   logic [7:0]  short_cnt_ff [SLOT_DEPTH];
   logic [7:0]  long_cnt_ff  [SLOT_DEPTH];
   logic [SLOT_DEPTH-1:0] short_vld_ff, short_vld_in;
   logic [SLOT_DEPTH-1:0] long_vld_ff,  long_vld_in;
   logic [wrb_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // Slot counts read while the request is captured
   logic [7:0]  short_rd_ff;
   logic [7:0]  long_rd_ff;

   logic [SLOT_AW-1:0] req_idx;
   logic [SLOT_AW-1:0] idx;
   logic        in_range;
   logic        is_long;
   logic        rd_short_vld, rd_long_vld;
   logic [7:0]  new_short, new_long;
   logic        wr_short, wr_long;
   logic [7:0]  bumped;
   logic [7:0]  limit;
   logic [15:0] grown;
   logic [14:0] grown_cap;
   logic [7:0]  retries;
   logic        limit_hit;
   logic        missing;
   logic        use_long;

   assign req_idx   = req_tdata[4 +: SLOT_AW];
   assign idx       = slot_ff[SLOT_AW-1:0];
   assign in_range  = {5'd0, slot_ff} < SLOT_LIMIT;
   assign is_long   = length_ff >= cfg.length_threshold;
   assign rd_short_vld = in_range & short_vld_ff[idx];
   assign rd_long_vld  = in_range & long_vld_ff[idx];
   assign new_short = rd_short_vld ? wrb_pkg::sat_inc(short_rd_ff) : 8'd1;
   assign new_long  = rd_long_vld ? wrb_pkg::sat_inc(long_rd_ff) : 8'd1;
   assign grown     = {window_ff, 1'b1};
   assign grown_cap = (grown > {1'b0, cfg.window_max}) ? cfg.window_max : grown[14:0];
   assign use_long  = (action_ff == wrb_pkg::ACT_QUERY_DATA) & is_long;

   always_comb begin
      window_in    = window_ff;
      sta_short_in = sta_short_ff;
      sta_long_in  = sta_long_ff;
      short_vld_in = short_vld_ff;
      long_vld_in  = long_vld_ff;
      wr_short     = 1'b0;
      wr_long      = 1'b0;
      bumped       = 8'd0;
      limit        = cfg.short_limit;
      retries      = 8'd0;
      limit_hit    = 1'b0;
      missing      = 1'b0;
      case (action_ff) inside
         wrb_pkg::ACT_CTS, wrb_pkg::ACT_BLOCKACK: begin
            sta_short_in = 8'd0;
         end
         wrb_pkg::ACT_ACK: begin
            if (is_long) sta_long_in = 8'd0;
            else         sta_short_in = 8'd0;
            window_in = cfg.window_min;
         end
         wrb_pkg::ACT_DATA_FAIL, wrb_pkg::ACT_RTS_FAIL: begin
            if ((action_ff == wrb_pkg::ACT_DATA_FAIL) && is_long) begin
               bumped      = wrb_pkg::sat_inc(sta_long_ff);
               limit       = cfg.long_limit;
               sta_long_in = bumped;
               wr_long     = in_range;
               retries     = in_range ? new_long : 8'd0;
            end else begin
               bumped       = wrb_pkg::sat_inc(sta_short_ff);
               sta_short_in = bumped;
               wr_short     = in_range;
               retries      = in_range ? new_short : 8'd0;
            end
            // Limit hit resets the window, otherwise grow it
            window_in = (bumped == limit) ? cfg.window_min : grown_cap;
            limit_hit = in_range & (retries >= limit);
         end
         wrb_pkg::ACT_GROUP_SENT: begin
            sta_short_in = 8'd0;
            sta_long_in  = 8'd0;
         end
         wrb_pkg::ACT_QUERY_DATA, wrb_pkg::ACT_QUERY_RTS: begin
            if (use_long) begin
               missing   = ~rd_long_vld;
               retries   = rd_long_vld ? long_rd_ff : 8'd0;
               limit_hit = rd_long_vld & (long_rd_ff >= cfg.long_limit);
            end else begin
               missing   = ~rd_short_vld;
               retries   = rd_short_vld ? short_rd_ff : 8'd0;
               limit_hit = rd_short_vld & (short_rd_ff >= cfg.short_limit);
            end
         end
         wrb_pkg::ACT_CLEAR_SLOT: begin
            if (in_range) begin
               short_vld_in[idx] = 1'b0;
               long_vld_in[idx]  = 1'b0;
            end
         end
         default: ;
      endcase
      if (wr_short) short_vld_in[idx] = 1'b1;
      if (wr_long)  long_vld_in[idx]  = 1'b1;
      rsp_data_in = {7'd0, missing, limit_hit, retries, sta_long_in, sta_short_in, window_in};
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff   <= req_tdata[3:0];
         slot_ff     <= req_tdata[7:4];
         length_ff   <= req_tdata[23:8];
         short_rd_ff <= short_cnt_ff[req_idx];
         long_rd_ff  <= long_cnt_ff[req_idx];
      end
      if (cmd.exec) begin
         rsp_data_ff <= rsp_data_in;
         if (wr_short) short_cnt_ff[idx] <= new_short;
         if (wr_long)  long_cnt_ff[idx]  <= new_long;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= wrb_pkg::WINDOW_MIN_RST;
         sta_short_ff <= 8'd0;
         sta_long_ff  <= 8'd0;
         short_vld_ff <= '0;
         long_vld_ff  <= '0;
      end else if (cmd.exec) begin
         window_ff    <= window_in;
         sta_short_ff <= sta_short_in;
         sta_long_ff  <= sta_long_in;
         short_vld_ff <= short_vld_in;
         long_vld_ff  <= long_vld_in;
      end
   end

   assign rsp_tdata = rsp_data_ff;

endmodule

// File: verif/testbench.sv
module testbench;

   // Actions with no defined meaning; the block must report its state unchanged.
   localparam logic [3:0] ACT_UNUSED_FIRST = 4'd9;
   localparam logic [3:0] ACT_UNUSED_LAST  = 4'd15;

   localparam int STALL_LIMIT     = 2000;  // cycles without any transfer
   localparam int SETTLE_CYCLES   = 8;     // idle margin after the reports drain
   localparam int RANDOM_PER_SET  = 80;
   localparam int PHASE_COUNT     = 5;

   // Request transfer layout, lowest field in the lowest bits.
   typedef struct packed {
      logic [15:0] frame_length;
      logic [3:0]  frame_slot;
      logic [3:0]  action;
   } event_item_type;

   // Response transfer layout, window_now in the lowest bits.
   typedef struct packed {
      logic [6:0]  pad;
      logic        entry_missing;
      logic        limit_reached;
      logic [7:0]  frame_retries;
      logic [7:0]  station_long_now;
      logic [7:0]  station_short_now;
      logic [14:0] window_now;
   } retry_report_type;

   // One directed row; the report is typed in only where fixed is set.
   typedef struct packed {
      logic [3:0]  action;
      logic [3:0]  frame_slot;
      logic [15:0] frame_length;
      logic        fixed;
      logic [14:0] window_now;
      logic [7:0]  station_short_now;
      logic [7:0]  station_long_now;
      logic [7:0]  frame_retries;
      logic        limit_reached;
      logic        entry_missing;
   } directed_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;   // [3:0] action, [7:4] frame_slot, [23:8] frame_length
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;   // [14:0] window_now, [22:15] station_short_now,
                             // [30:23] station_long_now, [38:31] frame_retries,
                             // [39] limit_reached, [40] entry_missing, [47:41] zero
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [4:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   wifi_retry_backoff_tracker i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Retry state tracker: own copy of the registers and counters
   // ---------------------------------------------------------------------
   wrb_pkg::cfg_type tracker_cfg;
   logic [14:0] tracker_window;
   logic [7:0]  tracker_ssrc;
   logic [7:0]  tracker_slrc;
   logic [7:0]  tracker_slot_short [16];
   logic [7:0]  tracker_slot_long [16];
   bit          tracker_short_valid [16];
   bit          tracker_long_valid [16];

   retry_report_type expected_reports [$];
   int            error_count;
   int            tx_idle_pct;
   int            rx_idle_pct;
   int            quiet_cycles;

   task automatic clear_tracker();
      tracker_cfg.short_limit      = wrb_pkg::SHORT_LIMIT_RST;
      tracker_cfg.long_limit       = wrb_pkg::LONG_LIMIT_RST;
      tracker_cfg.window_min       = wrb_pkg::WINDOW_MIN_RST;
      tracker_cfg.window_max       = wrb_pkg::WINDOW_MAX_RST;
      tracker_cfg.length_threshold = wrb_pkg::LEN_THRESH_RST;
      tracker_window = wrb_pkg::WINDOW_MIN_RST;
      tracker_ssrc   = '0;
      tracker_slrc   = '0;
      for (int s = 0; s < 16; s++) begin
         tracker_slot_short[s]  = '0;
         tracker_slot_long[s]   = '0;
         tracker_short_valid[s] = 1'b0;
         tracker_long_valid[s]  = 1'b0;
      end
   endtask

   function automatic logic [7:0] count_up(input logic [7:0] count);
      return (count == 8'hFF) ? count : count + 8'd1;
   endfunction

   // Bump a station counter and move the window: back to its minimum when
   // the counter lands exactly on its limit, else double plus one, capped.
   function automatic logic [7:0] bump_station(input logic [7:0] count,
                                               input logic [7:0] limit);
      logic [7:0] bumped;
      int         grown;
      bumped = count_up(count);
      if (bumped == limit) begin
         tracker_window = tracker_cfg.window_min;
      end else begin
         grown = 2 * int'(tracker_window) + 1;
         tracker_window = (grown > int'(tracker_cfg.window_max)) ?
                          tracker_cfg.window_max : 15'(grown);
      end
      return bumped;
   endfunction

   // An entry that was not valid restarts at one.
   function automatic logic [7:0] bump_slot(input bit long_side, input logic [3:0] slot);
      if (long_side) begin
         tracker_slot_long[slot] = tracker_long_valid[slot] ?
                                   count_up(tracker_slot_long[slot]) : 8'd1;
         tracker_long_valid[slot] = 1'b1;
         return tracker_slot_long[slot];
      end
      tracker_slot_short[slot] = tracker_short_valid[slot] ?
                                 count_up(tracker_slot_short[slot]) : 8'd1;
      tracker_short_valid[slot] = 1'b1;
      return tracker_slot_short[slot];
   endfunction

   function automatic retry_report_type apply_event(input event_item_type item);
      retry_report_type report;
      bit            is_long;
      bit            use_long;
      logic [7:0]    limit;
      report  = '0;
      is_long = item.frame_length >= tracker_cfg.length_threshold;
      case (item.action) inside
         wrb_pkg::ACT_CTS, wrb_pkg::ACT_BLOCKACK: tracker_ssrc = '0;
         wrb_pkg::ACT_ACK: begin
            if (is_long) tracker_slrc = '0;
            else tracker_ssrc = '0;
            tracker_window = tracker_cfg.window_min;
         end
         wrb_pkg::ACT_DATA_FAIL, wrb_pkg::ACT_RTS_FAIL: begin
            use_long = (item.action == wrb_pkg::ACT_DATA_FAIL) && is_long;
            limit    = use_long ? tracker_cfg.long_limit : tracker_cfg.short_limit;
            if (use_long) tracker_slrc = bump_station(tracker_slrc, limit);
            else tracker_ssrc = bump_station(tracker_ssrc, limit);
            report.frame_retries = bump_slot(use_long, item.frame_slot);
            report.limit_reached = report.frame_retries >= limit;
         end
         wrb_pkg::ACT_GROUP_SENT: begin
            tracker_ssrc = '0;
            tracker_slrc = '0;
         end
         wrb_pkg::ACT_QUERY_DATA, wrb_pkg::ACT_QUERY_RTS: begin
            use_long = (item.action == wrb_pkg::ACT_QUERY_DATA) && is_long;
            limit    = use_long ? tracker_cfg.long_limit : tracker_cfg.short_limit;
            if (!(use_long ? tracker_long_valid[item.frame_slot] :
                             tracker_short_valid[item.frame_slot])) begin
               report.entry_missing = 1'b1;
            end else begin
               report.frame_retries = use_long ? tracker_slot_long[item.frame_slot] :
                                                 tracker_slot_short[item.frame_slot];
               report.limit_reached = report.frame_retries >= limit;
            end
         end
         wrb_pkg::ACT_CLEAR_SLOT: begin
            tracker_slot_short[item.frame_slot]  = '0;
            tracker_slot_long[item.frame_slot]   = '0;
            tracker_short_valid[item.frame_slot] = 1'b0;
            tracker_long_valid[item.frame_slot]  = 1'b0;
         end
         default: ;
      endcase
      report.window_now        = tracker_window;
      report.station_short_now = tracker_ssrc;
      report.station_long_now  = tracker_slrc;
      return report;
   endfunction

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------

   // Idle at random, hold the transfer until taken, then log its report.
   // A fixed report replaces the tracker's, but the tracker still advances.
   task automatic send_event(input event_item_type item, input bit fixed,
                             input retry_report_type fixed_report);
      retry_report_type predicted;
      while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= item;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = apply_event(item);
      expected_reports.push_back(fixed ? fixed_report : predicted);
   endtask

   // Drop valid and hold until every report is back.
   task automatic drain_reports();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_reports.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(input logic [2:0] index, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
   endtask

   // Write every register; only call while the block is idle.
   task automatic load_settings(input wrb_pkg::cfg_type settings);
      write_register(wrb_pkg::REG_SHORT_LIMIT, 32'(settings.short_limit));
      write_register(wrb_pkg::REG_LONG_LIMIT,  32'(settings.long_limit));
      write_register(wrb_pkg::REG_WINDOW_MIN,  32'(settings.window_min));
      write_register(wrb_pkg::REG_WINDOW_MAX,  32'(settings.window_max));
      write_register(wrb_pkg::REG_LEN_THRESH,  32'(settings.length_threshold));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      tracker_cfg = settings;
   endtask

   // Lengths cluster on the class boundary and the field extremes.
   function automatic logic [15:0] pick_length();
      case ($urandom_range(5))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2:       return tracker_cfg.length_threshold - 16'd1;
         3:       return tracker_cfg.length_threshold;
         4:       return tracker_cfg.length_threshold + 16'd1;
         default: return 16'($urandom_range(65535));
      endcase
   endfunction

   function automatic event_item_type random_event();
      event_item_type item;
      int          roll;
      roll = $urandom_range(99);
      if (roll < 22)      item.action = wrb_pkg::ACT_DATA_FAIL;
      else if (roll < 36) item.action = wrb_pkg::ACT_RTS_FAIL;
      else if (roll < 48) item.action = wrb_pkg::ACT_QUERY_DATA;
      else if (roll < 58) item.action = wrb_pkg::ACT_QUERY_RTS;
      else if (roll < 68) item.action = wrb_pkg::ACT_ACK;
      else if (roll < 74) item.action = wrb_pkg::ACT_CTS;
      else if (roll < 78) item.action = wrb_pkg::ACT_BLOCKACK;
      else if (roll < 83) item.action = wrb_pkg::ACT_GROUP_SENT;
      else if (roll < 90) item.action = wrb_pkg::ACT_CLEAR_SLOT;
      else item.action = 4'($urandom_range(ACT_UNUSED_LAST, ACT_UNUSED_FIRST));
      // Stay on a few slots most of the time so entries build up.
      item.frame_slot   = ($urandom_range(3) != 0) ? 4'($urandom_range(3)) :
                                                     4'($urandom_range(15));
      item.frame_length = pick_length();
      return item;
   endfunction

   // Back-to-back failures on one slot with occasional queries; no clears,
   // so long bursts drive the counters into saturation.
   function automatic event_item_type burst_event(input logic [3:0] slot,
                                                  input logic [3:0] fail_action);
      event_item_type item;
      item.frame_slot   = slot;
      item.frame_length = pick_length();
      if ($urandom_range(19) == 0)
         item.action = $urandom_range(1) ? wrb_pkg::ACT_QUERY_DATA : wrb_pkg::ACT_QUERY_RTS;
      else
         item.action = fail_action;
      return item;
   endfunction

   // ---------------------------------------------------------------------
   // Response side
   // ---------------------------------------------------------------------

   always @(posedge clock) begin
      rsp_tready <= (rx_idle_pct == 0) || ($urandom_range(99) >= rx_idle_pct);
   end

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      retry_report_type want;
      retry_report_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (expected_reports.size() == 0) begin
            $display("%0t: unexpected response, expected none actual %h", $time, got);
            error_count++;
         end else begin
            want = expected_reports.pop_front();
            check_field("window_now",        want.window_now,        got.window_now);
            check_field("station_short_now", want.station_short_now, got.station_short_now);
            check_field("station_long_now",  want.station_long_now,  got.station_long_now);
            check_field("frame_retries",     want.frame_retries,     got.frame_retries);
            check_field("limit_reached",     want.limit_reached,     got.limit_reached);
            check_field("entry_missing",     want.entry_missing,     got.entry_missing);
            check_field("padding",           want.pad,               got.pad);
         end
      end
   end

   // Watchdog: end the run if nothing moves on any port for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: watchdog expired, no transfer for %0d cycles", $time, quiet_cycles);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   directed_row_type directed_rows [0:21];
   wrb_pkg::cfg_type settings_list [0:PHASE_COUNT-1];

   initial begin
      event_item_type   item;
      retry_report_type fixed_report;
      logic [3:0]    burst_slot;
      logic [3:0]    burst_action;
      int            burst_len;

      // Rows run from reset values: short limit 7, long limit 4, window 15..1023,
      // threshold 2346.
      directed_rows = '{
         // empty slots report a missing entry
         '{wrb_pkg::ACT_QUERY_DATA, 4'd0, 16'h0000, 1'b1, 15'd15, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1},
         '{wrb_pkg::ACT_QUERY_RTS, 4'd15, 16'hFFFF, 1'b1, 15'd15, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1},
         // short then long failure: window 31, then 63
         '{wrb_pkg::ACT_DATA_FAIL, 4'd0, 16'h0000, 1'b1, 15'd31, 8'd1, 8'd0, 8'd1, 1'b0, 1'b0},
         '{wrb_pkg::ACT_DATA_FAIL, 4'd15, 16'hFFFF, 1'b1, 15'd63, 8'd1, 8'd1, 8'd1, 1'b0, 1'b0},
         // RTS failure ignores the length class
         '{wrb_pkg::ACT_RTS_FAIL, 4'd0, 16'd2346, 1'b1, 15'd127, 8'd2, 8'd1, 8'd2, 1'b0, 1'b0},
         '{wrb_pkg::ACT_QUERY_DATA, 4'd0, 16'd2345, 1'b0, 15'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0},
         // length at the threshold is long; no long entry on slot 0
         '{wrb_pkg::ACT_QUERY_DATA, 4'd0, 16'd2346, 1'b1, 15'd127, 8'd2, 8'd1, 8'd0, 1'b0, 1'b1},
         '{wrb_pkg::ACT_QUERY_RTS, 4'd15, 16'h0000, 1'b1, 15'd127, 8'd2, 8'd1, 8'd0, 1'b0, 1'b1},
         // CTS and BlockAck clear SSRC and leave the window
         '{wrb_pkg::ACT_CTS, 4'd3, 16'h0000, 1'b1, 15'd127, 8'd0, 8'd1, 8'd0, 1'b0, 1'b0},
         '{wrb_pkg::ACT_BLOCKACK, 4'd12, 16'h5555, 1'b1, 15'd127, 8'd0, 8'd1, 8'd0, 1'b0, 1'b0},
         // long ACK clears SLRC and resets the window
         '{wrb_pkg::ACT_ACK, 4'd0, 16'hFFFF, 1'b1, 15'd15, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0},
         // long failures until SLRC meets its limit and the limit flag rises
         '{wrb_pkg::ACT_DATA_FAIL, 4'd15, 16'd3000, 1'b0, 15'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0},
         '{wrb_pkg::ACT_DATA_FAIL, 4'd15, 16'hFFFF, 1'b0, 15'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0},
         '{wrb_pkg::ACT_DATA_FAIL, 4'd15, 16'hFFFF, 1'b0, 15'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0},
         '{wrb_pkg::ACT_DATA_FAIL, 4'd15, 16'hFFFF, 1'b0, 15'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0},
         '{wrb_pkg::ACT_QUERY_DATA, 4'd15, 16'hFFFF, 1'b0, 15'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0},
         '{wrb_pkg::ACT_ACK, 4'd0, 16'h0000, 1'b0, 15'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0},
         '{wrb_pkg::ACT_GROUP_SENT, 4'd10, 16'hAAAA, 1'b0, 15'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0},
         // cleared slot reads as missing again
         '{wrb_pkg::ACT_CLEAR_SLOT, 4'd0, 16'h0000, 1'b0, 15'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0},
         '{wrb_pkg::ACT_QUERY_RTS, 4'd0, 16'h0000, 1'b0, 15'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0},
         // unused actions change nothing
         '{ACT_UNUSED_FIRST, 4'd5, 16'h1234, 1'b0, 15'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0},
         '{ACT_UNUSED_LAST, 4'd15, 16'hFFFF, 1'b0, 15'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0}
      };

      // Settings per phase: defaults, both extremes of every register, zero
      // limits, and a window maximum below the minimum.
      settings_list[0] = '{8'd7,   8'd4,   15'd15,    15'd1023,  16'd2346};
      settings_list[1] = '{8'd1,   8'd255, 15'd0,     15'd32767, 16'd0};
      settings_list[2] = '{8'd255, 8'd1,   15'd32767, 15'd0,     16'hFFFF};
      settings_list[3] = '{8'd0,   8'd0,   15'd3,     15'd100,   16'd1500};
      settings_list[4] = '{8'd3,   8'd2,   15'd1,     15'd31,    16'd512};

      error_count = 0;
      tx_idle_pct = 28;
      rx_idle_pct = 66;
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      clear_tracker();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < 22; r++) begin
         item.action       = directed_rows[r].action;
         item.frame_slot   = directed_rows[r].frame_slot;
         item.frame_length = directed_rows[r].frame_length;
         fixed_report = '0;
         fixed_report.window_now        = directed_rows[r].window_now;
         fixed_report.station_short_now = directed_rows[r].station_short_now;
         fixed_report.station_long_now  = directed_rows[r].station_long_now;
         fixed_report.frame_retries     = directed_rows[r].frame_retries;
         fixed_report.limit_reached     = directed_rows[r].limit_reached;
         fixed_report.entry_missing     = directed_rows[r].entry_missing;
         send_event(item, directed_rows[r].fixed, fixed_report);
      end

      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         drain_reports();
         repeat (SETTLE_CYCLES) @(posedge clock);
         load_settings(settings_list[ph]);

         // Sender idles lightly first, then the receiver side is light, then
         // both run flat out.
         if (ph < 2) begin
            tx_idle_pct = 28;
            rx_idle_pct = 66;
         end else if (ph < 4) begin
            tx_idle_pct = 66;
            rx_idle_pct = 28;
         end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end

         // Phases 1 and 2 carry long bursts that saturate SLRC and SSRC
         // (threshold 0 makes every data failure long).
         burst_slot = 4'($urandom_range(15));
         if (ph == 1) begin
            burst_len    = 300;
            burst_action = wrb_pkg::ACT_DATA_FAIL;
         end else if (ph == 2) begin
            burst_len    = 300;
            burst_action = wrb_pkg::ACT_RTS_FAIL;
         end else begin
            burst_len    = 40;
            burst_action = $urandom_range(1) ? wrb_pkg::ACT_DATA_FAIL : wrb_pkg::ACT_RTS_FAIL;
         end
         for (int n = 0; n < burst_len; n++)
            send_event(burst_event(burst_slot, burst_action), 1'b0, '0);

         for (int n = 0; n < RANDOM_PER_SET; n++) begin
            if (n == RANDOM_PER_SET / 2) drain_reports();
            send_event(random_event(), 1'b0, '0);
         end
      end

      drain_reports();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// File: files.f
src/wrb_pkg.sv
src/wrb_csr.sv
src/wrb_ctrl.sv
src/wrb_dpath.sv
src/wifi_retry_backoff_tracker.sv
verif/testbench.sv
